@@ rtl/bli_pkg.sv @@
// ----------------------------------------------------------------------------
// bli_pkg: shared types and constants for the byte list
// Command and error codes, the per-cell action code and the control word
// that the decoder broadcasts along the cell row.
// ----------------------------------------------------------------------------
package bli_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int POS_W     = 7;
	localparam int DATA_W    = 8;
	localparam int CNT_W     = 7;
	localparam int IN_W      = 24;
	localparam int OUT_W     = 24;

	typedef enum logic [2:0] {
		CMD_READ   = 3'd0,
		CMD_WRITE  = 3'd1,
		CMD_APPEND = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_ERASE  = 3'd4,
		CMD_INIT   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_RANGE = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		ACT_HOLD,
		ACT_LOAD,
		ACT_APPEND,
		ACT_INSERT,
		ACT_ERASE,
		ACT_CLEAR
	} act_t;

	typedef struct packed {
		act_t               act;
		logic [POS_W-1:0]   pos;
		logic [DATA_W-1:0]  val;
	} cell_ctl_t;

endpackage

@@ rtl/bli_dec.sv @@
// ----------------------------------------------------------------------------
// bli_dec: command decoder
// Checks range and fill, picks the cell action and the next fill count.
// ----------------------------------------------------------------------------
module bli_dec #(
	parameter int DEPTH = bli_pkg::DEPTH_DEF,
	parameter int UW    = $clog2(DEPTH + 1)
) (
	input  logic [2:0]                 cmd,
	input  logic [bli_pkg::POS_W-1:0]  pos,
	input  logic [bli_pkg::DATA_W-1:0] val,
	input  logic [UW-1:0]              used,
	output bli_pkg::cell_ctl_t         ctl,
	output bli_pkg::err_t              err,
	output logic [UW-1:0]              used_nx,
	output logic                       rd_en
);

	localparam int CW = (UW > bli_pkg::POS_W) ? UW : bli_pkg::POS_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [CW-1:0] pos_x;
	logic [CW-1:0] used_x;

	assign pos_x  = CW'(pos);
	assign used_x = CW'(used);

	always_comb begin
		ctl.act = bli_pkg::ACT_HOLD;
		ctl.pos = pos;
		ctl.val = val;
		err     = bli_pkg::ERR_OK;
		used_nx = used;
		rd_en   = 1'b0;
		unique case (bli_pkg::cmd_t'(cmd))
			bli_pkg::CMD_READ: begin
				if (pos_x >= used_x) err = bli_pkg::ERR_RANGE;
				else rd_en = 1'b1;
			end
			bli_pkg::CMD_WRITE: begin
				if (pos_x >= used_x) err = bli_pkg::ERR_RANGE;
				else ctl.act = bli_pkg::ACT_LOAD;
			end
			bli_pkg::CMD_APPEND: begin
				if (used_x >= DEPTH_C) err = bli_pkg::ERR_FULL;
				else begin
					ctl.act = bli_pkg::ACT_APPEND;
					used_nx = used + UW'(1);
				end
			end
			bli_pkg::CMD_INSERT: begin
				// range check wins over full
				if (pos_x > used_x) err = bli_pkg::ERR_RANGE;
				else if (used_x >= DEPTH_C) err = bli_pkg::ERR_FULL;
				else begin
					ctl.act = bli_pkg::ACT_INSERT;
					used_nx = used + UW'(1);
				end
			end
			bli_pkg::CMD_ERASE: begin
				if (pos_x >= used_x) err = bli_pkg::ERR_RANGE;
				else begin
					ctl.act = bli_pkg::ACT_ERASE;
					used_nx = used - UW'(1);
				end
			end
			bli_pkg::CMD_INIT: begin
				if (pos_x > DEPTH_C) err = bli_pkg::ERR_RANGE;
				else begin
					ctl.act = bli_pkg::ACT_CLEAR;
					used_nx = pos_x[UW-1:0];
				end
			end
			default: begin
				// unused codes: no effect
			end
		endcase
	end

endmodule

@@ rtl/bli_cell.sv @@
// ----------------------------------------------------------------------------
// bli_cell: one entry of the list
// Holds a byte; loads, clears or takes a neighbor's byte on a beat.
// ----------------------------------------------------------------------------
module bli_cell #(
	parameter int IDX = 0,
	parameter int UW  = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  bli_pkg::cell_ctl_t         ctl,
	input  logic [UW-1:0]              fill,
	input  logic [bli_pkg::DATA_W-1:0] left,
	input  logic [bli_pkg::DATA_W-1:0] right,
	output logic [bli_pkg::DATA_W-1:0] q,
	output logic [bli_pkg::DATA_W-1:0] rd
);

	localparam int CW = (UW > bli_pkg::POS_W) ? UW : bli_pkg::POS_W;
	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [bli_pkg::DATA_W-1:0] data_q;
	logic [bli_pkg::DATA_W-1:0] data_nx;
	logic [CW-1:0]              pos_x;
	logic                       at_pos;
	logic                       above_pos;
	logic                       at_fill;

	assign pos_x     = CW'(ctl.pos);
	assign at_pos    = (IDX_C == pos_x);
	assign above_pos = (IDX_C > pos_x);
	assign at_fill   = (IDX_C == CW'(fill));

	always_comb begin
		data_nx = data_q;
		unique case (ctl.act)
			bli_pkg::ACT_LOAD:   if (at_pos) data_nx = ctl.val;
			bli_pkg::ACT_APPEND: if (at_fill) data_nx = ctl.val;
			bli_pkg::ACT_INSERT: begin
				if (at_pos) data_nx = ctl.val;
				else if (above_pos) data_nx = left;
			end
			bli_pkg::ACT_ERASE:  if (at_pos || above_pos) data_nx = right;
			bli_pkg::ACT_CLEAR:  data_nx = '0;
			default:             data_nx = data_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) data_q <= '0;
		else if (en) data_q <= data_nx;
	end

	assign q  = data_q;
	assign rd = at_pos ? data_q : '0;

endmodule

@@ rtl/byte_list_insert_erase.sv @@
// ----------------------------------------------------------------------------
// byte_list_insert_erase: ordered byte list with insert and erase
// A row of DEPTH cells with a fill count; insert and erase shift the tail.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata, each carrying a command
//   (read, overwrite, append, insert, erase, init length), a position and a
//   byte. Every input beat yields exactly one output beat on
//   m_tvalid/m_tready/m_tdata with the byte read, the count after the
//   command and an error code (range or full). A failing command changes
//   nothing.
//   The result is registered and shows in the cycle after the beat is taken.
//   Throughput: one beat per cycle while the output is not stalled. Every cell
//   decides from the broadcast control word and its neighbors' bytes, so
//   insert and erase shift the whole tail on the edge that takes the beat;
//   the read path is an AND-OR over all cells into the output register.
//   Reset: all cells clear to zero, count to zero, output empty; no sweep.
//   Stall: the output register holds while m_tready is low; s_tready drops
//   only while a result is waiting and not being taken.
// ----------------------------------------------------------------------------
module byte_list_insert_erase #(
	parameter int DEPTH = bli_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// [2:0] command, [9:3] position, [17:10] value, [23:18] zero
	input  logic [bli_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [7:0] read_value, [14:8] count, [16:15] error, [23:17] zero
	output logic [bli_pkg::OUT_W-1:0] m_tdata
);

	localparam int UW = $clog2(DEPTH + 1);
	localparam int DW = bli_pkg::DATA_W;

	logic                 acc;
	logic [UW-1:0]        used_q;
	logic [UW-1:0]        used_nx;
	bli_pkg::cell_ctl_t   ctl;
	bli_pkg::err_t        err;
	logic                 rd_en;

	// cell row taps
	logic [DW-1:0]        cell_q  [DEPTH];
	logic [DW-1:0]        cell_rd [DEPTH];
	logic [DW-1:0]        rd_any;

	// output register
	logic                 out_valid_q;
	logic [DW-1:0]        rd_val_q;
	logic [bli_pkg::CNT_W-1:0] cnt_q;
	bli_pkg::err_t        err_q;

	assign s_tready = !out_valid_q || m_tready;
	assign acc      = s_tvalid && s_tready;

	bli_dec #(
		.DEPTH (DEPTH),
		.UW    (UW)
	) u_dec (
		.cmd     (s_tdata[2:0]),
		.pos     (s_tdata[9:3]),
		.val     (s_tdata[17:10]),
		.used    (used_q),
		.ctl     (ctl),
		.err     (err),
		.used_nx (used_nx),
		.rd_en   (rd_en)
	);

	// row of cells; cell i sees i-1 on the left and i+1 on the right
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DW-1:0] left_d;
		logic [DW-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_q[i+1];
		end
		bli_cell #(
			.IDX (i),
			.UW  (UW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (acc),
			.ctl    (ctl),
			.fill   (used_q),
			.left   (left_d),
			.right  (right_d),
			.q      (cell_q[i]),
			.rd     (cell_rd[i])
		);
	end

	// at most one cell matches the position
	always_comb begin
		rd_any = '0;
		for (int k = 0; k < DEPTH; k++) rd_any = rd_any | cell_rd[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) used_q <= used_nx;
			if (acc) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_val_q <= rd_en ? rd_any : '0;
			cnt_q    <= bli_pkg::CNT_W'(used_nx);
			err_q    <= err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, err_q, cnt_q, rd_val_q};

	// fill count stays within the store
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(DEPTH))
		else $error("fill count above depth");

	// a failing command leaves the count alone
	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (err != bli_pkg::ERR_OK) |=> $stable(used_q))
		else $error("count moved on error");

	// full is reported only on a full store
	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (err == bli_pkg::ERR_FULL) |-> used_q == UW'(DEPTH))
		else $error("full error on non-full store");

	// a pending result always reports the live count
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> cnt_q == bli_pkg::CNT_W'(used_q))
		else $error("reported count differs from fill count");

endmodule

@@ tb/byte_list_checker.sv @@
// ----------------------------------------------------------------------------
// byte_list_checker: result predictor and comparator for the byte list
// Watches both stream channels. Every input beat taken is run through a
// behavioral copy of the list and the expected result is queued; every
// output beat taken is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module byte_list_checker #(
	parameter int DEPTH = bli_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	// [2:0] command, [9:3] position, [17:10] value, [23:18] zero
	input  logic [bli_pkg::IN_W-1:0]  s_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	// [7:0] read_value, [14:8] count, [16:15] error, [23:17] zero
	input  logic [bli_pkg::OUT_W-1:0] m_tdata,
	output int                        errors,
	output int                        pending
);
	import bli_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] rd;
		logic [CNT_W-1:0]  cnt;
		err_t              err;
	} list_result_t;

	logic [DATA_W-1:0] cells [DEPTH];
	int                fill;
	list_result_t      result_q [$];
	list_result_t      got;
	list_result_t      want;
	int                beat_no;

	// Applies one command to the shadow list, returns the result it gives.
	function automatic list_result_t apply_command(logic [2:0] op, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] val);
		list_result_t res;
		int           p;
		p       = pos;
		res.rd  = '0;
		res.err = ERR_OK;
		case (op)
			CMD_READ: begin
				if (p >= fill) res.err = ERR_RANGE;
				else res.rd = cells[p];
			end
			CMD_WRITE: begin
				if (p >= fill) res.err = ERR_RANGE;
				else cells[p] = val;
			end
			CMD_APPEND: begin
				if (fill >= DEPTH) begin
					res.err = ERR_FULL;
				end else begin
					cells[fill] = val;
					fill++;
				end
			end
			CMD_INSERT: begin
				// range is checked ahead of full
				if (p > fill) begin
					res.err = ERR_RANGE;
				end else if (fill >= DEPTH) begin
					res.err = ERR_FULL;
				end else begin
					for (int i = fill; i > p; i--) cells[i] = cells[i-1];
					cells[p] = val;
					fill++;
				end
			end
			CMD_ERASE: begin
				if (p >= fill) begin
					res.err = ERR_RANGE;
				end else begin
					for (int i = p; i + 1 < fill; i++) cells[i] = cells[i+1];
					fill--;
				end
			end
			CMD_INIT: begin
				if (p > DEPTH) begin
					res.err = ERR_RANGE;
				end else begin
					foreach (cells[i]) cells[i] = '0;
					fill = p;
				end
			end
			default: ; // unused codes: no effect
		endcase
		res.cnt = CNT_W'(fill);
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[checker] beat %0d: %s", beat_no, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (cells[i]) cells[i] = '0;
			fill    = 0;
			result_q.delete();
			errors  = 0;
			pending = 0;
			beat_no = 0;
		end else begin
			// compare before pushing, so a stray result cannot match a fresh entry
			if (m_tvalid && m_tready) begin
				got.rd  = m_tdata[7:0];
				got.cnt = m_tdata[14:8];
				got.err = err_t'(m_tdata[16:15]);
				if (result_q.size() == 0) begin
					report_mismatch($sformatf("result with none expected (count %0d)", got.cnt));
				end else begin
					want = result_q.pop_front();
					if (got.rd !== want.rd)
						report_mismatch($sformatf("read_value %0d, expected %0d", got.rd, want.rd));
					if (got.cnt !== want.cnt)
						report_mismatch($sformatf("count %0d, expected %0d", got.cnt, want.cnt));
					if (got.err !== want.err)
						report_mismatch($sformatf("error %0d, expected %0d", got.err, want.err));
				end
				beat_no++;
			end
			if (s_tvalid && s_tready)
				result_q.push_back(apply_command(s_tdata[2:0], s_tdata[9:3], s_tdata[17:10]));
			pending = result_q.size();
		end
	end

endmodule

@@ tb/tb_byte_list_insert_erase.sv @@
// ----------------------------------------------------------------------------
// tb_byte_list_insert_erase: stimulus and verdict for the byte list
// A directed opening walks the error paths and the shift commands, then a
// long random run of mostly in-range commands keeps the list busy. Both
// channels stall at random; checking lives in byte_list_checker.
// ----------------------------------------------------------------------------
module tb_byte_list_insert_erase;
	import bli_pkg::*;

	localparam int RANDOM_BEATS = 1750;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 14;
	// beats within this window go through with no idling on either side
	localparam int STEADY_FIRST = 700;
	localparam int STEADY_LAST  = 1000;
	localparam int DRAIN_AT     = 1200;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;    // [2:0] command, [9:3] position, [17:10] value
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;    // [7:0] read_value, [14:8] count, [16:15] error
	int                errors;
	int                pending;
	int                cycles;
	int                list_len;   // rough length, only used to aim positions
	bit                steady;

	byte_list_insert_erase u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	byte_list_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[byte_list_insert_erase] ERROR");
			$finish;
		end
	end

	// sink side: random backpressure, none in the steady window
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// keeps list_len in step with the command so positions stay mostly in range
	function automatic void track_length(logic [2:0] op, int pos);
		case (op)
			CMD_APPEND: if (list_len < DEPTH_DEF) list_len++;
			CMD_INSERT: if (pos <= list_len && list_len < DEPTH_DEF) list_len++;
			CMD_ERASE:  if (pos < list_len) list_len--;
			CMD_INIT:   if (pos <= DEPTH_DEF) list_len = pos;
			default: ;
		endcase
	endfunction

	// one beat on the input side, with random idle cycles ahead of it
	task automatic send_command(logic [2:0] op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, val, pos, op};
		do @(posedge clk); while (!s_tready);
		track_length(op, pos);
	endtask

	// sender holds off until every result is back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic send_random();
		logic [2:0]        op;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		int                pick;
		val = DATA_W'($urandom);
		if ($urandom_range(0, 99) < 12) begin
			// noise: any code, any position, unused codes included
			op  = 3'($urandom_range(0, 7));
			pos = POS_W'($urandom_range(0, 127));
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 22) op = CMD_APPEND;
			else if (pick < 44) op = CMD_INSERT;
			else if (pick < 66) op = CMD_ERASE;
			else if (pick < 80) op = CMD_READ;
			else if (pick < 94) op = CMD_WRITE;
			else op = CMD_INIT;
			case (op)
				CMD_INSERT: pos = POS_W'($urandom_range(0, list_len));
				CMD_INIT:   pos = ($urandom_range(0, 3) == 0) ? POS_W'(DEPTH_DEF)
					: POS_W'($urandom_range(0, DEPTH_DEF));
				CMD_APPEND: pos = POS_W'($urandom_range(0, 127));
				default:    pos = (list_len > 0) ? POS_W'($urandom_range(0, list_len - 1)) : '0;
			endcase
		end
		send_command(op, pos, val);
	endtask

	initial begin
		int sent;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		cycles   = 0;
		list_len = 0;
		steady   = 1'b0;
		sent     = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed opening: errors on an empty list, then both ends of the store
		send_command(CMD_READ,   7'd0,   8'h00);   // read on empty list
		send_command(CMD_ERASE,  7'd0,   8'h00);   // erase on empty list
		send_command(CMD_WRITE,  7'd0,   8'h12);   // overwrite on empty list
		send_command(CMD_INSERT, 7'd1,   8'h34);   // insert past the end
		send_command(CMD_APPEND, 7'd0,   8'hFF);   // append to empty list
		send_command(CMD_INSERT, 7'd0,   8'h00);   // insert at head
		send_command(CMD_INSERT, 7'd2,   8'hA5);   // insert at the end acts as append
		send_command(CMD_READ,   7'd1,   8'h00);
		send_command(CMD_WRITE,  7'd2,   8'h5A);
		send_command(CMD_ERASE,  7'd0,   8'h00);   // erase head, tail shifts down
		send_command(CMD_READ,   7'd127, 8'hFF);   // largest position, out of range
		send_command(3'd6,       7'd127, 8'hFF);   // unused code, ignored
		send_command(3'd7,       7'd0,   8'h00);   // unused code, ignored
		send_command(CMD_INIT,   7'd65,  8'h00);   // init length past the store
		send_command(CMD_INIT,   7'd127, 8'h00);
		send_command(CMD_INIT,   7'd64,  8'h00);   // full list of zeros
		send_command(CMD_APPEND, 7'd0,   8'h77);   // append when full
		send_command(CMD_INSERT, 7'd64,  8'h77);   // insert when full
		send_command(CMD_INSERT, 7'd65,  8'h77);   // range wins over full
		send_command(CMD_WRITE,  7'd63,  8'hFF);   // last cell
		send_command(CMD_ERASE,  7'd63,  8'h00);   // erase last entry
		send_command(CMD_READ,   7'd62,  8'h00);
		send_command(CMD_INSERT, 7'd0,   8'h81);   // insert at head of a long list
		send_command(CMD_READ,   7'd0,   8'h00);
		send_command(CMD_INIT,   7'd0,   8'h00);   // back to empty
		drain_results();

		// random run; unused codes do not count toward the total
		while (sent < RANDOM_BEATS) begin
			steady = (sent >= STEADY_FIRST && sent < STEADY_LAST);
			if (sent == DRAIN_AT) drain_results();
			send_random();
			if (s_tdata[2:0] <= CMD_INIT) sent++;
		end
		steady = 1'b0;

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		if (errors == 0) begin
			$display("[byte_list_insert_erase] OK");
		end else begin
			$display("[byte_list_insert_erase] ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/bli_pkg.sv
rtl/bli_dec.sv
rtl/bli_cell.sv
rtl/byte_list_insert_erase.sv
tb/byte_list_checker.sv
tb/tb_byte_list_insert_erase.sv
